// ===== rtl/core/vmll_pkg.sv =====
`timescale 1ns / 1ps
package vmll_pkg;

  // Model geometry
  localparam int STATES   = 16;
  localparam int FEATURES = 32;
  localparam int STATE_W  = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int FEAT_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int ENTRY_W  = STATE_W + FEAT_W;
  localparam int TABLE_DEPTH = 1 << ENTRY_W;

  // Fixed-point widths
  localparam int ACC_W    = 40;
  localparam int CORDIC_W = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int SERIES_TERMS = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q29 = 34'sd843314856;
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic signed [31:0] LN2PI_Q16 = 32'sd120448;
  localparam logic [15:0]        KAPPA_SPLIT = 16'd2048;

  // Asymptotic correction numerators
  localparam logic [63:0] CORR_ONE = 64'd1 << 32;
  localparam logic [63:0] CORR_N1  = 64'd1 << 37;
  localparam logic [63:0] CORR_N2  = 64'd9 << 41;
  localparam logic [63:0] CORR_N3  = 64'd75 << 46;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_OBS  = 1'b1;

  // Fraction bits handed to the log unit
  localparam logic [5:0] LN_FRAC_Q32   = 6'd32;
  localparam logic [5:0] LN_FRAC_KAPPA = 6'd8;

  typedef logic signed [16:0]      trig_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic signed [ACC_W+1:0] ACC_MAX_X = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W+1:0] ACC_MIN_X = {3'b111, {(ACC_W-1){1'b0}}};
  localparam acc_t LP_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam acc_t LP_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // arctan(2^-i) in Q.29
  function automatic logic signed [CORDIC_W-1:0] atan_q29(input logic [3:0] i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      4'd0:    v = 34'sd421657428;
      4'd1:    v = 34'sd248918915;
      4'd2:    v = 34'sd131521918;
      4'd3:    v = 34'sd66762579;
      4'd4:    v = 34'sd33510843;
      4'd5:    v = 34'sd16771758;
      4'd6:    v = 34'sd8387925;
      4'd7:    v = 34'sd4194219;
      4'd8:    v = 34'sd2097141;
      4'd9:    v = 34'sd1048575;
      4'd10:   v = 34'sd524288;
      4'd11:   v = 34'sd262144;
      4'd12:   v = 34'sd131072;
      4'd13:   v = 34'sd65536;
      4'd14:   v = 34'sd32768;
      default: v = 34'sd16384;
    endcase
    return v;
  endfunction

  // Clamp a widened sum into the accumulator range
  function automatic acc_t sat_acc(input logic signed [ACC_W+1:0] v);
    acc_t r;
    if (v > ACC_MAX_X) r = ACC_MAX_X[ACC_W-1:0];
    else if (v < ACC_MIN_X) r = ACC_MIN_X[ACC_W-1:0];
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  // Clamp an accumulator to the 32-bit result
  function automatic logic signed [31:0] sat32(input acc_t v);
    logic signed [31:0] r;
    if (v > LP_MAX) r = 32'sh7fffffff;
    else if (v < LP_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/vmll_item_if.sv =====
`timescale 1ns / 1ps
interface vmll_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  state_index;
  logic [7:0]  feature_index;
  logic signed [15:0] angle;
  logic [15:0] concentration;
  logic        last_feature;

  modport source (output valid, cmd, state_index, feature_index, angle, concentration,
                  last_feature, input ready);
  modport sink (input valid, cmd, state_index, feature_index, angle, concentration,
                last_feature, output ready);
endinterface

// ===== rtl/core/vmll_result_if.sv =====
`timescale 1ns / 1ps
interface vmll_result_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_state;
  logic signed [31:0] log_prob;
  logic        last_state;

  modport source (output valid, out_state, log_prob, last_state, input ready);
  modport sink (input valid, out_state, log_prob, last_state, output ready);
endinterface

// ===== rtl/core/vmll_ram.sv =====
`timescale 1ns / 1ps
module vmll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vmll_cordic.sv =====
`timescale 1ns / 1ps
module vmll_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output vmll_pkg::trig_t    cos_q,
  output vmll_pkg::trig_t    sin_q
);

  typedef enum logic [1:0] {C_IDLE, C_ROT, C_FIN} cstate_t;

  cstate_t cstate;
  logic signed [vmll_pkg::CORDIC_W-1:0] x, y, z;
  logic signed [vmll_pkg::CORDIC_W-1:0] z_in, z_fold, xs, ys, x_out, y_out, x_rnd, y_rnd;
  logic neg, neg_in;
  logic [3:0] step;

  // Fold the angle into the right half-plane
  always_comb begin
    z_in = {{2{angle[15]}}, angle, 16'b0};
    if (z_in > vmll_pkg::HALF_PI_Q29) begin
      z_fold = z_in - vmll_pkg::PI_Q29;
      neg_in = 1'b1;
    end else if (z_in < -vmll_pkg::HALF_PI_Q29) begin
      z_fold = z_in + vmll_pkg::PI_Q29;
      neg_in = 1'b1;
    end else begin
      z_fold = z_in;
      neg_in = 1'b0;
    end
    xs = x >>> step;
    ys = y >>> step;
    x_out = neg ? -x : x;
    y_out = neg ? -y : y;
    x_rnd = x_out + 34'sd32768;
    y_rnd = y_out + 34'sd32768;
  end

  // One rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cstate)
        C_IDLE: begin
          if (start) begin
            x      <= vmll_pkg::CORDIC_K;
            y      <= '0;
            z      <= z_fold;
            neg    <= neg_in;
            step   <= '0;
            cstate <= C_ROT;
          end
        end
        C_ROT: begin
          if (!z[vmll_pkg::CORDIC_W-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - vmll_pkg::atan_q29(step);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + vmll_pkg::atan_q29(step);
          end
          if (step == 4'(vmll_pkg::CORDIC_STEPS - 1)) begin
            cstate <= C_FIN;
          end else begin
            step <= step + 4'd1;
          end
        end
        C_FIN: begin
          cos_q  <= x_rnd[32:16];
          sin_q  <= y_rnd[32:16];
          done   <= 1'b1;
          cstate <= C_IDLE;
        end
        default: cstate <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/vmll_div.sv =====
`timescale 1ns / 1ps
module vmll_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t dstate;
  logic [63:0] rem, dvs;
  logic [5:0]  cnt;
  logic [64:0] trial, diff;

  always_comb begin
    trial = {rem, quotient[63]};
    diff  = trial - {1'b0, dvs};
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (start) begin
            rem      <= '0;
            quotient <= dividend;
            dvs      <= divisor;
            cnt      <= 6'd63;
            dstate   <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[64]) begin
            rem      <= diff[63:0];
            quotient <= {quotient[62:0], 1'b1};
          end else begin
            rem      <= trial[63:0];
            quotient <= {quotient[62:0], 1'b0};
          end
          if (cnt == 6'd0) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/vmll_ln.sv =====
`timescale 1ns / 1ps
module vmll_ln (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        x,
  input  logic [5:0]         frac,
  output logic               done,
  output logic signed [31:0] result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR, L_FIN} lstate_t;

  lstate_t lstate;
  logic [63:0] xr;
  logic [5:0]  pcnt, frac_r;
  logic [30:0] m;
  logic signed [23:0] l2;
  logic [3:0]  step;
  logic signed [7:0]  l2_int;
  logic [61:0] sq;
  logic [31:0] sh;
  logic signed [56:0] lprod, lrnd;

  always_comb begin
    l2_int = $signed({2'b00, pcnt}) - $signed({2'b00, frac_r});
    sq     = {31'b0, m} * {31'b0, m};
    sh     = sq[61:30];
    lprod  = 57'(l2) * 57'($signed({1'b0, vmll_pkg::LN2_Q32}));
    lrnd   = lprod + 57'sd2147483648;
  end

  // Normalise, then square the mantissa once per fraction bit
  always_ff @(posedge clk) begin
    if (rst) begin
      lstate <= L_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (lstate)
        L_IDLE: begin
          if (start) begin
            xr     <= (x == 64'd0) ? 64'd1 : x;
            pcnt   <= 6'd63;
            frac_r <= frac;
            lstate <= L_NORM;
          end
        end
        L_NORM: begin
          if (xr[63]) begin
            m      <= xr[63:33];
            l2     <= {l2_int, 16'b0};
            step   <= 4'd15;
            lstate <= L_SQR;
          end else begin
            xr   <= {xr[62:0], 1'b0};
            pcnt <= pcnt - 6'd1;
          end
        end
        L_SQR: begin
          if (sh[31]) begin
            m <= sh[31:1];
            l2[{1'b0, step}] <= 1'b1;
          end else begin
            m <= sh[30:0];
          end
          if (step == 4'd0) begin
            lstate <= L_FIN;
          end else begin
            step <= step - 4'd1;
          end
        end
        L_FIN: begin
          result <= 32'($signed(lrnd[56:32]));
          done   <= 1'b1;
          lstate <= L_IDLE;
        end
        default: lstate <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/von_mises_state_log_likelihood.sv =====
`timescale 1ns / 1ps
// An observation runs the CORDIC, then walks the accumulators one state at a time (one shared
// multiplier, two products per state); a final feature adds one result beat per state. A load
// below kappa 8.0 runs 24 series divisions in the serial divider, and above it the asymptotic
// correction instead. One item at a time: input ready only while idle. Reset clears the
// sequencer, the accumulators and the result valid flag.
module von_mises_state_log_likelihood (
  input logic         clk,
  input logic         rst,
  vmll_item_if.sink   item,
  vmll_result_if.source result
);

  typedef enum logic [4:0] {
    S_IDLE, S_SINCOS, S_LD_KC, S_LD_KS, S_N_SQ, S_N_SQ_CAP, S_N_ML, S_N_MH, S_N_MS, S_N_DIV,
    S_N_LN_GO, S_N_LN_WAIT, S_B_K3, S_B_K3_CAP, S_B_DIV_GO, S_B_DIV_WAIT, S_B_LN1_GO,
    S_B_LN1_WAIT, S_B_LN2_GO, S_B_LN2_WAIT, S_WRITE, S_O_READ, S_O_MUL1, S_O_MUL2, S_O_ACC,
    S_EMIT
  } state_t;

  state_t state;

  // Latched item
  logic        cmd_r, last_r;
  logic [5:0]  st_r;
  logic [7:0]  ft_r;
  logic [15:0] kappa_r;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // Load datapath
  logic [31:0] kc, ks, norm, k2;
  logic [47:0] k3;
  logic [19:0] tval;
  logic [63:0] term, nsum, lo, corr, full;
  logic [4:0]  mcount;
  logic [9:0]  msq;
  logic [1:0]  dsel;
  logic signed [31:0] ln1;
  logic signed [33:0] half_t, big_norm;
  logic signed [65:0] rnd_p;

  // Observation datapath
  logic [vmll_pkg::STATE_W-1:0] k;
  logic signed [49:0] dot, dsum;
  vmll_pkg::acc_t acc [vmll_pkg::STATES];
  vmll_pkg::acc_t a1, a2;

  // Result register
  logic        res_valid, res_last;
  logic [5:0]  res_state;
  logic signed [31:0] res_prob;

  // Units
  logic        cs_done;
  vmll_pkg::trig_t cs_cos, cs_sin;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_divisor, div_q;
  logic        ln_start, ln_done;
  logic [63:0] ln_x;
  logic [5:0]  ln_frac;
  logic signed [31:0] ln_res;

  // Tables
  logic        ram_we;
  logic [vmll_pkg::ENTRY_W-1:0] ram_addr;
  logic [31:0] kc_rd, ks_rd, norm_rd;

  logic accept, load_ok, feat_ok, k_last;

  assign accept  = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign load_ok = ({1'b0, st_r} < 7'(vmll_pkg::STATES)) &&
                   ({1'b0, ft_r} < 9'(vmll_pkg::FEATURES));
  assign feat_ok = ({1'b0, ft_r} < 9'(vmll_pkg::FEATURES));
  assign k_last  = (k == vmll_pkg::STATE_W'(vmll_pkg::STATES - 1));

  assign result.valid      = res_valid;
  assign result.out_state  = res_state;
  assign result.log_prob   = res_prob;
  assign result.last_state = res_last;

  vmll_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .angle (item.angle),
    .done  (cs_done),
    .cos_q (cs_cos),
    .sin_q (cs_sin)
  );

  vmll_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  vmll_ln u_ln (
    .clk    (clk),
    .rst    (rst),
    .start  (ln_start),
    .x      (ln_x),
    .frac   (ln_frac),
    .done   (ln_done),
    .result (ln_res)
  );

  vmll_ram #(.WIDTH(32), .DEPTH(vmll_pkg::TABLE_DEPTH)) u_kc_ram (
    .clk (clk), .we (ram_we), .waddr (ram_addr), .wdata (kc), .raddr (ram_addr), .rdata (kc_rd)
  );

  vmll_ram #(.WIDTH(32), .DEPTH(vmll_pkg::TABLE_DEPTH)) u_ks_ram (
    .clk (clk), .we (ram_we), .waddr (ram_addr), .wdata (ks), .raddr (ram_addr), .rdata (ks_rd)
  );

  vmll_ram #(.WIDTH(32), .DEPTH(vmll_pkg::TABLE_DEPTH)) u_norm_ram (
    .clk (clk), .we (ram_we), .waddr (ram_addr), .wdata (norm), .raddr (ram_addr),
    .rdata (norm_rd)
  );

  // Table address and write strobe
  always_comb begin
    ram_we   = (state == S_WRITE);
    ram_addr = (state == S_WRITE) ?
               {st_r[vmll_pkg::STATE_W-1:0], ft_r[vmll_pkg::FEAT_W-1:0]} :
               {k, ft_r[vmll_pkg::FEAT_W-1:0]};
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LD_KC: begin
        mul_a = $signed({17'b0, kappa_r});
        mul_b = 33'(cs_cos);
      end
      S_LD_KS: begin
        mul_a = $signed({17'b0, kappa_r});
        mul_b = 33'(cs_sin);
      end
      S_N_SQ: begin
        mul_a = $signed({17'b0, kappa_r});
        mul_b = $signed({17'b0, kappa_r});
      end
      S_B_K3: begin
        mul_a = $signed({1'b0, k2});
        mul_b = $signed({17'b0, kappa_r});
      end
      S_N_ML: begin
        mul_a = $signed({1'b0, term[31:0]});
        mul_b = $signed({13'b0, tval});
      end
      S_N_MH: begin
        mul_a = $signed({1'b0, term[63:32]});
        mul_b = $signed({13'b0, tval});
      end
      S_O_MUL1: begin
        mul_a = 33'($signed(kc_rd));
        mul_b = 33'(cs_cos);
      end
      S_O_MUL2: begin
        mul_a = 33'($signed(ks_rd));
        mul_b = 33'(cs_sin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider and log unit requests
  always_comb begin
    full  = {prod[31:0], 32'b0} + lo;
    msq   = {5'b0, mcount} * {5'b0, mcount};
    rnd_p = prod + 66'sd32;
    div_start    = (state == S_N_MS) || (state == S_B_DIV_GO);
    div_dividend = {16'b0, full[63:16]};
    div_divisor  = {54'b0, msq};
    if (state == S_B_DIV_GO) begin
      case (dsel)
        2'd0: begin
          div_dividend = vmll_pkg::CORR_N1;
          div_divisor  = {48'b0, kappa_r};
        end
        2'd1: begin
          div_dividend = vmll_pkg::CORR_N2;
          div_divisor  = {32'b0, k2};
        end
        default: begin
          div_dividend = vmll_pkg::CORR_N3;
          div_divisor  = {16'b0, k3};
        end
      endcase
    end
    ln_start = (state == S_N_LN_GO) || (state == S_B_LN1_GO) || (state == S_B_LN2_GO);
    ln_x     = nsum;
    ln_frac  = vmll_pkg::LN_FRAC_Q32;
    if (state == S_B_LN1_GO) begin
      ln_x    = {48'b0, kappa_r};
      ln_frac = vmll_pkg::LN_FRAC_KAPPA;
    end else if (state == S_B_LN2_GO) begin
      ln_x = corr;
    end
    half_t   = (34'(vmll_pkg::LN2PI_Q16) + 34'(ln1)) >>> 1;
    big_norm = 34'(vmll_pkg::LN2PI_Q16) + $signed({10'b0, kappa_r, 8'b0}) - half_t
               + 34'(ln_res);
  end

  // Accumulator update for one state
  always_comb begin
    dsum = dot + $signed(prod[49:0]) + 50'sd8192;
    a1 = vmll_pkg::sat_acc(42'(acc[k]) + 42'($signed(dsum[49:14])));
    a2 = vmll_pkg::sat_acc(42'(a1) - 42'($signed(norm_rd)));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      k         <= '0;
      for (int i = 0; i < vmll_pkg::STATES; i++) begin
        acc[i] <= '0;
      end
    end else begin
      // Drop the result once taken; the emit state reloads the slot itself
      if (res_valid && result.ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= item.cmd;
            st_r    <= item.state_index;
            ft_r    <= item.feature_index;
            kappa_r <= item.concentration;
            last_r  <= item.last_feature;
            state   <= S_SINCOS;
          end
        end
        S_SINCOS: begin
          if (cs_done) begin
            k <= '0;
            if (cmd_r == vmll_pkg::CMD_LOAD) begin
              state <= load_ok ? S_LD_KC : S_IDLE;
            end else if (feat_ok) begin
              state <= S_O_READ;
            end else begin
              state <= last_r ? S_EMIT : S_IDLE;
            end
          end
        end
        S_LD_KC: state <= S_LD_KS;
        S_LD_KS: begin
          kc    <= rnd_p[37:6];
          state <= S_N_SQ;
        end
        S_N_SQ: begin
          ks    <= rnd_p[37:6];
          state <= S_N_SQ_CAP;
        end
        S_N_SQ_CAP: begin
          k2     <= prod[31:0];
          tval   <= prod[21:2];
          term   <= vmll_pkg::CORR_ONE;
          nsum   <= vmll_pkg::CORR_ONE;
          mcount <= 5'd1;
          state  <= (kappa_r < vmll_pkg::KAPPA_SPLIT) ? S_N_ML : S_B_K3;
        end
        S_N_ML: state <= S_N_MH;
        S_N_MH: begin
          lo    <= prod[63:0];
          state <= S_N_MS;
        end
        S_N_MS: state <= S_N_DIV;
        S_N_DIV: begin
          if (div_done) begin
            term <= div_q;
            nsum <= nsum + div_q;
            if (mcount == 5'(vmll_pkg::SERIES_TERMS)) begin
              state <= S_N_LN_GO;
            end else begin
              mcount <= mcount + 5'd1;
              state  <= S_N_ML;
            end
          end
        end
        S_N_LN_GO: state <= S_N_LN_WAIT;
        S_N_LN_WAIT: begin
          if (ln_done) begin
            norm  <= vmll_pkg::LN2PI_Q16 + ln_res;
            state <= S_WRITE;
          end
        end
        S_B_K3: state <= S_B_K3_CAP;
        S_B_K3_CAP: begin
          k3    <= prod[47:0];
          corr  <= vmll_pkg::CORR_ONE;
          dsel  <= 2'd0;
          state <= S_B_DIV_GO;
        end
        S_B_DIV_GO: state <= S_B_DIV_WAIT;
        S_B_DIV_WAIT: begin
          if (div_done) begin
            corr <= corr + div_q;
            if (dsel == 2'd2) begin
              state <= S_B_LN1_GO;
            end else begin
              dsel  <= dsel + 2'd1;
              state <= S_B_DIV_GO;
            end
          end
        end
        S_B_LN1_GO: state <= S_B_LN1_WAIT;
        S_B_LN1_WAIT: begin
          if (ln_done) begin
            ln1   <= ln_res;
            state <= S_B_LN2_GO;
          end
        end
        S_B_LN2_GO: state <= S_B_LN2_WAIT;
        S_B_LN2_WAIT: begin
          if (ln_done) begin
            norm  <= big_norm[31:0];
            state <= S_WRITE;
          end
        end
        S_WRITE: state <= S_IDLE;
        S_O_READ: state <= S_O_MUL1;
        S_O_MUL1: state <= S_O_MUL2;
        S_O_MUL2: begin
          dot   <= prod[49:0];
          state <= S_O_ACC;
        end
        S_O_ACC: begin
          acc[k] <= a2;
          if (k_last) begin
            k     <= '0;
            state <= last_r ? S_EMIT : S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_O_READ;
          end
        end
        S_EMIT: begin
          // Load one result beat whenever the slot is free
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_state <= 6'(k);
            res_prob  <= vmll_pkg::sat32(acc[k]);
            res_last  <= k_last;
            acc[k]    <= '0;
            if (k_last) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/vmll_checker.sv =====
`timescale 1ns / 1ps
module vmll_checker (
  input  logic    clk,
  input  logic    rst,
  vmll_item_if    item,
  vmll_result_if  result,
  output int      errors,
  output int      pending
);

  typedef struct {
    logic [5:0]         out_state;
    logic signed [31:0] log_prob;
    logic               last_state;
  } score_t;

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  // arctan(2^-i) in Q.29
  localparam longint ATAN_TAB [16] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384};

  int     kc_mem   [vmll_pkg::STATES*vmll_pkg::FEATURES];
  int     ks_mem   [vmll_pkg::STATES*vmll_pkg::FEATURES];
  int     norm_mem [vmll_pkg::STATES*vmll_pkg::FEATURES];
  longint state_sum [vmll_pkg::STATES];
  score_t expected_scores [$];

  assign pending = expected_scores.size();

  function automatic longint clamp40(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // CORDIC cosine and sine of a Q3.13 angle, both Q.14
  function automatic void trig_q14(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = ang * 65536;
    x = vmll_pkg::CORDIC_K;
    y = 0;
    flip = 0;
    if (z > longint'(vmll_pkg::HALF_PI_Q29)) begin
      z -= longint'(vmll_pkg::PI_Q29);
      flip = 1;
    end else if (z < -longint'(vmll_pkg::HALF_PI_Q29)) begin
      z += longint'(vmll_pkg::PI_Q29);
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
  endfunction

  // Natural log of x / 2^frac in Q16.16
  function automatic longint natlog_q16(input longint unsigned x, input int frac);
    int p;
    longint unsigned m;
    longint l2;
    if (x == 0) x = 1;
    p = 63;
    while (((x >> p) & 1) == 0) p--;
    m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
    l2 = longint'(p - frac) * 65536;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        l2 += longint'(1) << i;
      end
    end
    return (l2 * longint'(vmll_pkg::LN2_Q32) + 64'sd2147483648) >>> 32;
  endfunction

  // log(2*pi) + log(I0(kappa)), kappa Q8.8
  function automatic longint von_mises_norm(input longint unsigned kappa);
    longint unsigned t, term, total, k2, corr;
    longint lni0;
    if (kappa < vmll_pkg::KAPPA_SPLIT) begin
      t = (kappa * kappa) >> 2;
      term = 64'd1 << 32;
      total = term;
      for (longint unsigned m = 1; m <= 24; m++) begin
        term = ((term * t) >> 16) / (m * m);
        total += term;
      end
      lni0 = natlog_q16(total, 32);
    end else begin
      k2 = kappa * kappa;
      corr = (64'd1 << 32) + (64'd1 << 37) / kappa + (64'd9 << 41) / k2
           + (64'd75 << 46) / (k2 * kappa);
      lni0 = longint'(kappa) * 256
           - ((longint'(vmll_pkg::LN2PI_Q16) + natlog_q16(kappa, 8)) >>> 1)
           + natlog_q16(corr, 32);
    end
    return longint'(vmll_pkg::LN2PI_Q16) + lni0;
  endfunction

  // Apply one accepted beat to the model state and queue any scores
  task automatic absorb_item();
    longint c, s, dot, a, v, kap;
    int idx;
    score_t sc;
    trig_q14(longint'(item.angle), c, s);
    kap = longint'(item.concentration);
    if (item.cmd == vmll_pkg::CMD_LOAD) begin
      if (item.state_index < vmll_pkg::STATES && item.feature_index < vmll_pkg::FEATURES) begin
        idx = item.state_index * vmll_pkg::FEATURES + item.feature_index;
        kc_mem[idx]   = int'((kap * c + 32) >>> 6);
        ks_mem[idx]   = int'((kap * s + 32) >>> 6);
        norm_mem[idx] = int'(von_mises_norm(kap));
      end
    end else begin
      if (item.feature_index < vmll_pkg::FEATURES) begin
        for (int k = 0; k < vmll_pkg::STATES; k++) begin
          idx = k * vmll_pkg::FEATURES + item.feature_index;
          dot = c * kc_mem[idx] + s * ks_mem[idx];
          a = clamp40(state_sum[k] + ((dot + 8192) >>> 14));
          state_sum[k] = clamp40(a - norm_mem[idx]);
        end
      end
      if (item.last_feature) begin
        for (int k = 0; k < vmll_pkg::STATES; k++) begin
          v = state_sum[k];
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          sc.out_state  = 6'(k);
          sc.log_prob   = 32'(v);
          sc.last_state = (k == vmll_pkg::STATES - 1);
          expected_scores.push_back(sc);
          state_sum[k] = 0;
        end
      end
    end
  endtask

  // Compare one result beat with the oldest expected score
  task automatic check_score();
    score_t sc;
    if (expected_scores.size() == 0) begin
      $error("unexpected result beat: state %0d log_prob %0d", result.out_state,
             result.log_prob);
      errors++;
      return;
    end
    sc = expected_scores.pop_front();
    if (result.out_state !== sc.out_state) begin
      $error("out_state: expected %0d, got %0d", sc.out_state, result.out_state);
      errors++;
    end
    if (result.log_prob !== sc.log_prob) begin
      $error("log_prob: expected %0d, got %0d", sc.log_prob, result.log_prob);
      errors++;
    end
    if (result.last_state !== sc.last_state) begin
      $error("last_state: expected %0d, got %0d", sc.last_state, result.last_state);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    for (int k = 0; k < vmll_pkg::STATES; k++) state_sum[k] = 0;
  end

  // Watch both channels on every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item.valid && item.ready) absorb_item();
      if (result.valid && result.ready) check_score();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 0;
  int   errors, pending;
  int   n_items = 0, n_loads = 0, n_obs = 0, n_frames = 0;
  bit   loaded [vmll_pkg::STATES][vmll_pkg::FEATURES];

  vmll_item_if   item ();
  vmll_result_if result ();

  von_mises_state_log_likelihood uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  vmll_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always #10 clk = ~clk;

  // Stall the result side at random unless in a quiet stretch
  always @(posedge clk) begin
    result.ready <= quiet || ($urandom_range(99) >= 26);
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one beat, idling first at random, and hold until accepted
  task automatic send_item(input logic c, input logic [5:0] st, input logic [7:0] ft,
                           input logic [15:0] ang, input logic [15:0] kap,
                           input logic lst);
    while (!quiet && $urandom_range(99) < 26) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid         <= 1'b1;
    item.cmd           <= c;
    item.state_index   <= st;
    item.feature_index <= ft;
    item.angle         <= ang;
    item.concentration <= kap;
    item.last_feature  <= lst;
    do @(negedge clk); while (!item.ready);
    @(posedge clk);
    n_items++;
    if (c == vmll_pkg::CMD_LOAD) begin
      n_loads++;
      if (st < vmll_pkg::STATES && ft < vmll_pkg::FEATURES) loaded[st][ft] = 1;
    end else begin
      n_obs++;
      if (lst) n_frames++;
    end
  endtask

  function automatic bit feature_ready(input int ft);
    if (ft >= vmll_pkg::FEATURES) return 1;
    for (int k = 0; k < vmll_pkg::STATES; k++)
      if (!loaded[k][ft]) return 0;
    return 1;
  endfunction

  function automatic logic [15:0] rand_kappa();
    if ($urandom_range(99) < 80) return 16'($urandom_range(2047));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_feature();
    int ft;
    if ($urandom_range(99) < 10) return 8'($urandom_range(255, vmll_pkg::FEATURES));
    do ft = $urandom_range(vmll_pkg::FEATURES - 1); while (!feature_ready(ft));
    return 8'(ft);
  endfunction

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  localparam logic [15:0] DIR_KAPPA [16] = '{
    16'd0, 16'd1, 16'd2047, 16'd2048, 16'd65535, 16'd256, 16'd1024, 16'd4096,
    16'd32768, 16'd512, 16'd3000, 16'd2, 16'd100, 16'd20000, 16'd1500, 16'd8191};
  localparam logic [15:0] DIR_ANGLE [16] = '{
    16'h8000, 16'h7fff, 16'h0000, 16'd12868, -16'sd12868, 16'd12869, 16'hffff,
    16'd25736, -16'sd25736, 16'd1, 16'd6434, -16'sd6434, 16'd20000, 16'h4000,
    16'hc000, 16'd30000};

  initial begin
    int flen;
    item.valid         <= 1'b0;
    item.cmd           <= vmll_pkg::CMD_LOAD;
    item.state_index   <= '0;
    item.feature_index <= '0;
    item.angle         <= '0;
    item.concentration <= '0;
    item.last_feature  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: load feature 0 at extreme kappa and angles, then edge cases
    for (int k = 0; k < vmll_pkg::STATES; k++)
      send_item(vmll_pkg::CMD_LOAD, 6'(k), 8'd0, DIR_ANGLE[k], DIR_KAPPA[k], 1'b0);
    send_item(vmll_pkg::CMD_LOAD, 6'd63, 8'd0, 16'h1234, 16'd777, 1'b0);
    send_item(vmll_pkg::CMD_LOAD, 6'd5, 8'd255, 16'h4321, 16'd777, 1'b0);
    send_item(vmll_pkg::CMD_LOAD, 6'd3, 8'd200, 16'h0100, 16'd50, 1'b1);
    send_item(vmll_pkg::CMD_OBS, 6'd0, 8'd0, 16'h8000, 16'hffff, 1'b0);
    send_item(vmll_pkg::CMD_OBS, 6'd63, 8'd0, 16'h7fff, 16'd0, 1'b1);
    send_item(vmll_pkg::CMD_OBS, 6'd0, 8'd200, 16'h0000, 16'd0, 1'b1);

    // Fill three more features so random frames have a choice
    for (int f = 1; f <= 3; f++)
      for (int k = 0; k < vmll_pkg::STATES; k++)
        send_item(vmll_pkg::CMD_LOAD, 6'(k), 8'(f), 16'($urandom), rand_kappa(),
                  1'($urandom));

    // Hold off until every score is in before the saturation frame
    drain();
    quiet = 1;
    for (int k = 0; k < vmll_pkg::STATES; k++)
      send_item(vmll_pkg::CMD_LOAD, 6'(k), 8'd3, 16'd0, 16'd65535, 1'b0);
    for (int i = 0; i < 140; i++)
      send_item(vmll_pkg::CMD_OBS, 6'($urandom), 8'd3, -16'sd25736, 16'($urandom),
                i == 139);
    quiet = 0;

    // Random: mostly well-formed frames, some reloads and ignored loads
    while (n_items < 350) begin
      case ($urandom_range(99) / 10)
        0, 1:
          send_item(vmll_pkg::CMD_LOAD, 6'($urandom_range(vmll_pkg::STATES - 1)),
                    8'($urandom_range(vmll_pkg::FEATURES - 1)), 16'($urandom), rand_kappa(),
                    1'($urandom));
        2:
          send_item(vmll_pkg::CMD_LOAD, 6'($urandom_range(63, vmll_pkg::STATES)),
                    8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        default: begin
          flen = $urandom_range(6, 1);
          for (int i = 0; i < flen; i++)
            send_item(vmll_pkg::CMD_OBS, 6'($urandom), pick_feature(), 16'($urandom),
                      16'($urandom), i == flen - 1);
        end
      endcase
    end
    item.valid <= 1'b0;

    drain();
    repeat (300) @(posedge clk);
    $display("Ran %0d beats: %0d table loads, %0d observations in %0d frames,",
             n_items, n_loads, n_obs, n_frames);
    $display("including ignored loads, out-of-range features and saturated scores.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
